@@ rtl/lmbs_pkg.sv @@
`timescale 1ns / 1ps

package lmbs_pkg;

    // store geometry
    localparam int STORE_BYTES  = 16;
    localparam int MATRIX_LEDS  = 60;
    localparam int IDX_W        = 4;
    localparam logic [IDX_W-1:0] STATUS_BYTE = IDX_W'(STORE_BYTES - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 4'd1;
    localparam logic [CFG_W-1:0] ON_TIME_RESET = 14'd256;
    localparam logic [CFG_W-1:0] PERIOD_RESET  = 14'd1024;

    // request types
    localparam logic [1:0] REQ_SET_LED    = 2'd0;
    localparam logic [1:0] REQ_SET_STATUS = 2'd1;
    localparam logic [1:0] REQ_CLEAR_ALL  = 2'd2;
    localparam logic [1:0] REQ_TICK       = 2'd3;

    // colour codes
    localparam logic [1:0] COL_OFF    = 2'd0;
    localparam logic [1:0] COL_GREEN  = 2'd1;
    localparam logic [1:0] COL_RED    = 2'd2;
    localparam logic [1:0] COL_ORANGE = 2'd3;

    // internal command operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  led_number;
        logic [1:0]  colour;
        logic        blink_flag;
        logic [7:0]  status_row;
        logic        status_on;
        logic [31:0] now_ms;
    } lmbs_req_t;

    typedef struct packed {
        logic [3:0] group_select;
        logic [7:0] latch_byte_0;
        logic [7:0] latch_byte_1;
        logic [7:0] latch_byte_2;
        logic [7:0] latch_byte_3;
        logic       blink_phase;
    } lmbs_res_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       mask;
        logic [7:0]       cval;
        logic [7:0]       bval;
        logic [31:0]      now_ms;
    } lmbs_cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] on_time;
        logic [CFG_W-1:0] period;
    } lmbs_cfg_t;

endpackage

@@ rtl/lmbs_front.sv @@
`timescale 1ns / 1ps

module lmbs_front (
    input  logic                  start,
    input  logic                  full,
    input  lmbs_pkg::lmbs_req_t   req,
    output logic                  push,
    output lmbs_pkg::lmbs_cmd_t   cmd
);

    logic       led_ok;
    logic       row_ok;
    logic [7:0] nm1;
    logic [2:0] shift;
    logic [1:0] pair;
    logic       keep;

    assign led_ok = (req.led_number >= 8'd1)
                 && (req.led_number <= 8'(lmbs_pkg::MATRIX_LEDS));
    assign row_ok = (req.status_row <= 8'd7);
    assign nm1    = req.led_number - 8'd1;
    assign shift  = {nm1[1:0], 1'b0};

    // {hi, lo}: hi is the green bit, lo the red bit
    always_comb
    begin
        unique case (req.colour)
            lmbs_pkg::COL_OFF:    pair = 2'b00;
            lmbs_pkg::COL_GREEN:  pair = 2'b10;
            lmbs_pkg::COL_RED:    pair = 2'b01;
            lmbs_pkg::COL_ORANGE: pair = 2'b11;
            default:              pair = 2'b00;
        endcase
    end

    always_comb
    begin
        cmd.op     = lmbs_pkg::OP_WRITE;
        cmd.idx    = '0;
        cmd.mask   = '0;
        cmd.cval   = '0;
        cmd.bval   = '0;
        cmd.now_ms = req.now_ms;
        keep       = 1'b0;
        unique case (req.req_type)
            lmbs_pkg::REQ_SET_LED:
            begin
                cmd.op   = lmbs_pkg::OP_WRITE;
                cmd.idx  = nm1[5:2];
                cmd.mask = 8'h03 << shift;
                cmd.cval = {6'd0, pair} << shift;
                cmd.bval = {6'd0, pair & {2{req.blink_flag}}} << shift;
                keep     = led_ok;
            end
            lmbs_pkg::REQ_SET_STATUS:
            begin
                cmd.op   = lmbs_pkg::OP_WRITE;
                cmd.idx  = lmbs_pkg::STATUS_BYTE;
                cmd.mask = 8'h01 << req.status_row[2:0];
                cmd.cval = {7'd0, req.status_on} << req.status_row[2:0];
                cmd.bval = {7'd0, req.blink_flag} << req.status_row[2:0];
                keep     = row_ok;
            end
            lmbs_pkg::REQ_CLEAR_ALL:
            begin
                cmd.op = lmbs_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            lmbs_pkg::REQ_TICK:
            begin
                cmd.op = lmbs_pkg::OP_TICK;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // ignored items are dropped here and never queued
    assign push = start && !full && keep;

endmodule

@@ rtl/lmbs_queue.sv @@
`timescale 1ns / 1ps

module lmbs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lmbs_pkg::lmbs_cmd_t   push_cmd,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output lmbs_pkg::lmbs_cmd_t   pop_cmd
);

    lmbs_pkg::lmbs_cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/lmbs_back.sv @@
`timescale 1ns / 1ps

module lmbs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  lmbs_pkg::lmbs_cmd_t   cmd,
    input  lmbs_pkg::lmbs_cfg_t   cfg,
    output logic                  pop,
    output logic                  result_strobe,
    output lmbs_pkg::lmbs_res_t   result
);

    logic [7:0]  colour_reg [lmbs_pkg::STORE_BYTES];
    logic [7:0]  blink_reg  [lmbs_pkg::STORE_BYTES];
    logic        lit_reg, lit_next;
    logic [31:0] last_reg, last_next;
    logic [1:0]  group_reg, group_next;
    logic        strobe_reg, strobe_next;
    lmbs_pkg::lmbs_res_t res_reg, res_next;

    logic        is_tick;
    logic [31:0] diff;
    logic [3:0]  base;

    assign pop     = !empty;
    assign is_tick = pop && (cmd.op == lmbs_pkg::OP_TICK);
    assign diff    = cmd.now_ms - last_reg;
    assign base    = {2'b00, group_reg} + {1'b0, group_reg, 1'b0};

    function automatic logic [7:0] shown(input logic [7:0] c, input logic [7:0] b,
                                         input logic lit);
        shown = lit ? c : (c ^ b);
    endfunction

    always_comb
    begin
        lit_next    = lit_reg;
        last_next   = last_reg;
        group_next  = group_reg;
        strobe_next = is_tick;
        res_next    = res_reg;
        if (is_tick)
        begin
            priority if (diff > {18'd0, cfg.period})
            begin
                lit_next  = 1'b1;
                last_next = cmd.now_ms;
            end
            else if (lit_reg && (diff > {18'd0, cfg.on_time}))
            begin
                lit_next = 1'b0;
            end
            else
            begin
                lit_next = lit_reg;
            end
            group_next            = group_reg + 2'd1;
            res_next.group_select = 4'b0001 << group_reg;
            res_next.latch_byte_0 = shown(colour_reg[base], blink_reg[base], lit_next);
            res_next.latch_byte_1 = shown(colour_reg[base + 4'd1], blink_reg[base + 4'd1],
                                          lit_next);
            res_next.latch_byte_2 = shown(colour_reg[base + 4'd2], blink_reg[base + 4'd2],
                                          lit_next);
            res_next.latch_byte_3 = shown(colour_reg[{2'b11, group_reg}],
                                          blink_reg[{2'b11, group_reg}], lit_next);
            res_next.blink_phase  = lit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg    <= 1'b0;
            last_reg   <= '0;
            group_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            lit_reg    <= lit_next;
            last_reg   <= last_next;
            group_reg  <= group_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // store update: masked write of one byte, or clear of all but the status byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmbs_pkg::STORE_BYTES; i++)
            begin
                colour_reg[i] <= '0;
                blink_reg[i]  <= '0;
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < lmbs_pkg::STORE_BYTES; i++)
            begin
                if (cmd.op == lmbs_pkg::OP_CLEAR)
                begin
                    if (lmbs_pkg::IDX_W'(i) != lmbs_pkg::STATUS_BYTE)
                    begin
                        colour_reg[i] <= '0;
                        blink_reg[i]  <= '0;
                    end
                end
                else if ((cmd.op == lmbs_pkg::OP_WRITE) && (cmd.idx == lmbs_pkg::IDX_W'(i)))
                begin
                    colour_reg[i] <= (colour_reg[i] & ~cmd.mask) | cmd.cval;
                    blink_reg[i]  <= (blink_reg[i] & ~cmd.mask) | cmd.bval;
                end
            end
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

@@ rtl/led_matrix_blink_scanner.sv @@
`timescale 1ns / 1ps

// a scan tick is written into the command queue, then executed by the back end, which
// registers its group together with the result strobe for the receiver to take
// throughput: one transaction per cycle; the two-entry command queue drains every cycle
// busy rises only if the queue fills, which the back end never lets happen
// here the receiver cannot stall: each result is held for exactly one cycle
// reset: asynchronous active low; stores, blink phase, period start, scan group clear
module led_matrix_blink_scanner (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request transaction
    input  logic                                  start,
    output logic                                  busy,
    input  lmbs_pkg::lmbs_req_t                   req,
    // result transaction
    output logic                                  result_strobe,
    output lmbs_pkg::lmbs_res_t                   result,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [lmbs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lmbs_pkg::CFG_W-1:0]            cfg_data
);

    // blink timing registers, reset to 256 and 1024 ms
    logic [lmbs_pkg::CFG_W-1:0] on_time_reg, on_time_next;
    logic [lmbs_pkg::CFG_W-1:0] period_reg, period_next;
    lmbs_pkg::lmbs_cfg_t cfg;

    // front to queue
    logic                push;
    logic                full;
    lmbs_pkg::lmbs_cmd_t push_cmd;

    // queue to back
    logic                empty;
    logic                pop;
    lmbs_pkg::lmbs_cmd_t pop_cmd;

    always_comb
    begin
        on_time_next = on_time_reg;
        period_next  = period_reg;
        if (cfg_we)
        begin
            // indexes outside the register list are ignored
            if (cfg_index == lmbs_pkg::CFG_ON_TIME)
            begin
                on_time_next = cfg_data;
            end
            else if (cfg_index == lmbs_pkg::CFG_PERIOD)
            begin
                period_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg <= lmbs_pkg::ON_TIME_RESET;
            period_reg  <= lmbs_pkg::PERIOD_RESET;
        end
        else
        begin
            on_time_reg <= on_time_next;
            period_reg  <= period_next;
        end
    end

    assign cfg.on_time = on_time_reg;
    assign cfg.period  = period_reg;

    // a request is taken whenever the queue has room
    assign busy = full;

    // front: decodes the request into a masked byte write, a clear or a tick,
    // and drops out-of-range led numbers and status rows
    lmbs_front u_front (
        .start (start),
        .full  (full),
        .req   (req),
        .push  (push),
        .cmd   (push_cmd)
    );

    // short command queue between decode and execution
    lmbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .pop_cmd  (pop_cmd)
    );

    // back: owns the colour and blink stores, the blink phase and the scan group,
    // and registers one scan group per tick
    lmbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .cmd           (pop_cmd),
        .cfg           (cfg),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

@@ tb/led_matrix_blink_scanner_test.sv @@
`timescale 1ns / 1ps

module led_matrix_blink_scanner_test;

    import lmbs_pkg::*;

    // an index the block does not decode, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;
    localparam logic [CFG_W-1:0]     CFG_MAX       = 14'd16320;
    // cycles with no accepted transaction before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // cycles allowed after the last expected group for anything still in flight
    localparam int SETTLE_CYCLES = 6;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    lmbs_req_t            req;
    logic                 result_strobe;
    lmbs_res_t            result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // mirror of the block state, kept in step with every accepted transaction
    logic [7:0]       colour_mem [STORE_BYTES];
    logic [7:0]       blink_mem  [STORE_BYTES];
    logic             lit_phase;
    logic [31:0]      period_start_ms;
    logic [1:0]       next_group;
    logic [CFG_W-1:0] on_time_ms;
    logic [CFG_W-1:0] period_ms;

    // scan groups predicted but not yet seen on the result port
    lmbs_res_t pending_groups[$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int          gap_odds;        // one chance in gap_odds of a sender gap, 0 turns gaps off
    logic [31:0] clock_ms;        // running millisecond clock for random ticks

    always #6 clk = ~clk;

    led_matrix_blink_scanner i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // byte as it appears on a latch: plain while lit, blink bits toggled while dark
    function automatic logic [7:0] shown_byte(input int idx);
        return lit_phase ? colour_mem[idx] : colour_mem[idx] ^ blink_mem[idx];
    endfunction

    // apply one accepted transaction to the mirror, queue a scan group on ticks
    task automatic predict_request(input lmbs_req_t r);
        lmbs_res_t   group;
        logic [31:0] elapsed;
        int          n;
        int          byte_idx;
        int          shift;
        logic        hi;
        logic        lo;
        case (r.req_type)
            REQ_SET_LED:
            begin
                // led numbers outside 1..60 leave the stores alone
                if (r.led_number >= 1 && r.led_number <= MATRIX_LEDS)
                begin
                    n        = r.led_number - 1;
                    byte_idx = n / 4;
                    shift    = 2 * (n % 4);
                    hi       = (r.colour == COL_GREEN) || (r.colour == COL_ORANGE);
                    lo       = (r.colour == COL_RED) || (r.colour == COL_ORANGE);
                    colour_mem[byte_idx][shift + 1] = hi;
                    colour_mem[byte_idx][shift]     = lo;
                    // blink bits only stay on where the colour bit is set
                    blink_mem[byte_idx][shift + 1]  = hi & r.blink_flag;
                    blink_mem[byte_idx][shift]      = lo & r.blink_flag;
                end
            end
            REQ_SET_STATUS:
            begin
                // rows above 7 are dropped
                if (r.status_row <= 8'd7)
                begin
                    colour_mem[STATUS_BYTE][r.status_row[2:0]] = r.status_on;
                    blink_mem[STATUS_BYTE][r.status_row[2:0]]  = r.blink_flag;
                end
            end
            REQ_CLEAR_ALL:
            begin
                // the status byte survives a clear
                for (int i = 0; i < STORE_BYTES - 1; i++)
                begin
                    colour_mem[i] = 8'h00;
                    blink_mem[i]  = 8'h00;
                end
            end
            default:
            begin
                // tick: wrapping difference against the start of the current period
                elapsed = r.now_ms - period_start_ms;
                if (elapsed > {18'd0, period_ms})
                begin
                    lit_phase       = 1'b1;
                    period_start_ms = r.now_ms;
                end
                else if (lit_phase && elapsed > {18'd0, on_time_ms})
                begin
                    lit_phase = 1'b0;
                end
                group.group_select = 4'b0001 << next_group;
                group.latch_byte_0 = shown_byte(3 * next_group);
                group.latch_byte_1 = shown_byte(3 * next_group + 1);
                group.latch_byte_2 = shown_byte(3 * next_group + 2);
                group.latch_byte_3 = shown_byte(12 + next_group);
                group.blink_phase  = lit_phase;
                pending_groups.push_back(group);
                next_group = next_group + 2'd1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected, actual);
            error_count++;
        end
    endtask

    // every strobe must match the oldest predicted scan group
    always @(posedge clk)
    begin
        lmbs_res_t exp_group;
        if (rst_n && result_strobe)
        begin
            if (pending_groups.size() == 0)
            begin
                $error("scan group 0x%0h arrived with none expected", result);
                error_count++;
            end
            else
            begin
                exp_group = pending_groups.pop_front();
                check_field("group_select", exp_group.group_select, result.group_select);
                check_field("latch_byte_0", exp_group.latch_byte_0, result.latch_byte_0);
                check_field("latch_byte_1", exp_group.latch_byte_1, result.latch_byte_1);
                check_field("latch_byte_2", exp_group.latch_byte_2, result.latch_byte_2);
                check_field("latch_byte_3", exp_group.latch_byte_3, result.latch_byte_3);
                check_field("blink_phase", exp_group.blink_phase, result.blink_phase);
            end
        end
    end

    // watchdog: any accepted request or result restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("led_matrix_blink_scanner test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic lmbs_req_t make_request(input logic [1:0] kind, input logic [7:0] led,
                                               input logic [1:0] colour, input logic blink,
                                               input logic [7:0] row, input logic on,
                                               input logic [31:0] now);
        lmbs_req_t r;
        r.req_type   = kind;
        r.led_number = led;
        r.colour     = colour;
        r.blink_flag = blink;
        r.status_row = row;
        r.status_on  = on;
        r.now_ms     = now;
        return r;
    endfunction

    // random gap of random length on the request side
    task automatic maybe_pause();
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // hold one transaction on the port until it is taken; start stays high for back to back
    task automatic send_request(input lmbs_req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_request(r);
        maybe_pause();
    endtask

    // wait for every predicted group, then let the pipeline empty
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_groups.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued with the block drained
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ON_TIME)
            on_time_ms = value;
        else if (idx == CFG_PERIOD)
            period_ms = value;
        @(posedge clk);
    endtask

    task automatic set_blink_timing(input logic [CFG_W-1:0] on_time, input logic [CFG_W-1:0] period);
        drain();
        write_config(CFG_ON_TIME, on_time);
        write_config(CFG_PERIOD, period);
    endtask

    // random transaction: mostly well-formed writes and ticks that walk through the blink cycle
    function automatic lmbs_req_t random_request();
        lmbs_req_t r;
        int        pick;
        r.led_number = 8'($urandom);
        r.colour     = 2'($urandom);
        r.blink_flag = 1'($urandom);
        r.status_row = 8'($urandom);
        r.status_on  = 1'($urandom);
        r.now_ms     = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 7)
        begin
            r.req_type = REQ_SET_LED;
            if ($urandom_range(0, 7) != 0)
                r.led_number = 8'($urandom_range(1, MATRIX_LEDS));
        end
        else if (pick < 10)
        begin
            r.req_type = REQ_SET_STATUS;
            if ($urandom_range(0, 7) != 0)
                r.status_row = 8'($urandom_range(0, 7));
        end
        else if (pick == 10)
        begin
            r.req_type = REQ_CLEAR_ALL;
        end
        else
        begin
            r.req_type = REQ_TICK;
            pick = $urandom_range(0, 31);
            // most ticks step the clock by a fraction of the period so every phase is crossed
            if (pick == 0)
                clock_ms = $urandom;
            else if (pick == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 64);
            else
                clock_ms = clock_ms + $urandom_range(0, period_ms / 3 + 4);
            if (pick != 2)
                r.now_ms = clock_ms;
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // led and status writes at the edges of their ranges, dropped numbers included
    task automatic test_store_writes();
        send_request(make_request(REQ_SET_LED, 8'd1, COL_GREEN, 1'b1, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_SET_LED, 8'd2, COL_RED, 1'b0, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_SET_LED, 8'd60, COL_ORANGE, 1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF));
        send_request(make_request(REQ_SET_LED, 8'd59, COL_OFF, 1'b1, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_SET_LED, 8'd0, COL_RED, 1'b1, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_SET_LED, 8'd61, COL_ORANGE, 1'b1, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_SET_LED, 8'd255, COL_GREEN, 1'b1, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_SET_STATUS, 8'hFF, COL_ORANGE, 1'b1, 8'd0, 1'b1, 32'd0));
        send_request(make_request(REQ_SET_STATUS, 8'd0, COL_OFF, 1'b0, 8'd7, 1'b1, 32'd0));
        send_request(make_request(REQ_SET_STATUS, 8'd0, COL_OFF, 1'b1, 8'd8, 1'b1, 32'd0));
        send_request(make_request(REQ_SET_STATUS, 8'd0, COL_OFF, 1'b1, 8'd255, 1'b0, 32'd0));
    endtask

    // blink phase with the reset timing: dark start, lit, dark again, then a wrap of the clock
    task automatic test_blink_phase();
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd1025));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd1200));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd1300));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'hFFFF_FFFF));
        // elapsed time wraps through zero here
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd5));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd300));
    endtask

    // clear all keeps the status byte, seen on the next group 3 scan
    task automatic test_clear_all();
        send_request(make_request(REQ_CLEAR_ALL, 8'd1, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd0));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd400));
        send_request(make_request(REQ_TICK, 8'd0, COL_OFF, 1'b0, 8'd0, 1'b0, 32'd2000));
    endtask

    // random traffic under the timing extremes and a write to an unused index
    task automatic test_timing_extremes();
        set_blink_timing(14'd0, 14'd0);
        write_config(CFG_SPARE_IDX, 14'h3FFF);
        run_random(70);
        set_blink_timing(CFG_MAX, CFG_MAX);
        run_random(70);
        set_blink_timing(CFG_MAX, 14'd0);
        run_random(70);
        set_blink_timing(14'd0, CFG_MAX);
        run_random(70);
        set_blink_timing(14'd3, 14'd9);
        run_random(70);
    endtask

    // random timing settings, then a closing stretch with no gaps at all
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            set_blink_timing(14'($urandom_range(0, CFG_MAX)), 14'($urandom_range(0, CFG_MAX)));
            gap_odds = (phase % 2 == 0) ? 4 : 12;
            run_random(80);
        end
        set_blink_timing(14'($urandom_range(0, 200)), 14'($urandom_range(0, 600)));
        gap_odds = 0;
        run_random(150);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gap_odds  = 4;
        clock_ms  = 32'd0;
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            colour_mem[i] = 8'h00;
            blink_mem[i]  = 8'h00;
        end
        lit_phase       = 1'b0;
        period_start_ms = 32'd0;
        next_group      = 2'd0;
        on_time_ms      = ON_TIME_RESET;
        period_ms       = PERIOD_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_store_writes();
        test_blink_phase();
        test_clear_all();
        test_timing_extremes();
        test_random_traffic();
        drain();

        if (error_count == 0)
            $display("led_matrix_blink_scanner test passed");
        else
            $display("led_matrix_blink_scanner test failed");
        $finish;
    end

endmodule

@@ led_matrix_blink_scanner.f @@
rtl/lmbs_pkg.sv
rtl/lmbs_front.sv
rtl/lmbs_queue.sv
rtl/lmbs_back.sv
rtl/led_matrix_blink_scanner.sv
tb/led_matrix_blink_scanner_test.sv
